// ===== rtl/bth_pkg.sv =====
`timescale 1ns / 1ps
package bth_pkg;

  // Sizing of the block table, the trace stack and one block.
  localparam int MAX_BLOCKS  = 4096;
  localparam int STACK_DEPTH = 64;
  localparam int BLOCK_BYTES = 16;

  localparam int BLK_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = BLK_W + 1;
  localparam int HINT_W = BLK_W - 2;
  localparam int STK_W  = $clog2(STACK_DEPTH);
  localparam int SCNT_W = STK_W + 1;
  localparam int OFS_W  = $clog2(BLOCK_BYTES);
  localparam int NEED_W = 33 - OFS_W;

  // Block kinds in the allocation table.
  localparam logic [1:0] K_FREE = 2'd0;
  localparam logic [1:0] K_HEAD = 2'd1;
  localparam logic [1:0] K_TAIL = 2'd2;
  localparam logic [1:0] K_MARK = 2'd3;

  // Command codes.
  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_ALLOC  = 3'd1;
  localparam logic [2:0] CMD_MARK   = 3'd2;
  localparam logic [2:0] CMD_POP    = 3'd3;
  localparam logic [2:0] CMD_RESCAN = 3'd4;
  localparam logic [2:0] CMD_SWEEP  = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_POOL_BASE   = 1'b0;
  localparam logic CFG_POOL_BLOCKS = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [BLK_W-1:0] block_index;
    logic [CNT_W-1:0] block_count;
    logic [31:0]      address;
    logic             overflowed;
  } out_item_t;

  typedef struct packed {
    logic [31:0]      base;
    logic [CNT_W-1:0] blocks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [BLK_W-1:0] blk;
    logic [CNT_W-1:0] cnt;
    logic             has_addr;
    logic             ovf;
  } res_t;

endpackage

// ===== rtl/bth_ram.sv =====
`timescale 1ns / 1ps
module bth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bth_seq.sv =====
`timescale 1ns / 1ps
module bth_seq
  import bth_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res_o,
  output logic              tab_we,
  output logic [BLK_W-1:0]  tab_waddr,
  output logic [1:0]        tab_wdata,
  output logic [BLK_W-1:0]  tab_raddr,
  input  logic [1:0]        tab_rdata,
  output logic              stk_we,
  output logic [STK_W-1:0]  stk_waddr,
  output logic [BLK_W-1:0]  stk_wdata,
  output logic [STK_W-1:0]  stk_raddr,
  input  logic [BLK_W-1:0]  stk_rdata
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_A_RD, S_A_EV, S_A_WR, S_M_CHK, S_M_RD, S_M_EV,
    S_P_RD, S_P_EV, S_L_RD, S_L_EV, S_R_START, S_R_RD, S_R_EV,
    S_W_RD, S_W_EV, S_OUT
  } state_t;

  localparam logic [BLK_W-1:0] LAST_BLK = BLK_W'(MAX_BLOCKS - 1);

  state_t              state_r, state_nxt;
  res_t                res_r, res_nxt;
  logic [NEED_W-1:0]   need_r, need_nxt;
  logic [31:0]         val_r, val_nxt;
  logic [CNT_W-1:0]    cur_r, cur_nxt;
  logic [CNT_W-1:0]    walk_r, walk_nxt;
  logic [BLK_W-1:0]    ptr_r, ptr_nxt;
  logic [BLK_W-1:0]    blk_r, blk_nxt;
  logic [CNT_W-1:0]    run_r, run_nxt;
  logic [BLK_W-1:0]    last_r, last_nxt;
  logic                drop_r, drop_nxt;
  logic                pass_r, pass_nxt;
  logic [SCNT_W-1:0]   scnt_r, scnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic [HINT_W-1:0]   hint_r, hint_nxt;
  logic [BLK_W-1:0]    hu_r, hu_nxt;
  logic                active_r, active_nxt;
  logic                clr_emit_r, clr_emit_nxt;

  logic [CNT_W-1:0]    nb;
  logic                in_xfer;

  function automatic res_t mk_res(logic [1:0] st, logic [BLK_W-1:0] b,
                                  logic [CNT_W-1:0] n, logic has);
    res_t r;
    r.status   = st;
    r.blk      = b;
    r.cnt      = n;
    r.has_addr = has;
    r.ovf      = 1'b0;
    return r;
  endfunction

  // Usable block count: clamped to the table size, rounded down to a multiple of four.
  always_comb begin
    nb = (cfg.blocks > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg.blocks;
    nb[1:0] = 2'b00;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign res_valid = (state_r == S_OUT);

  always_comb begin
    res_o     = res_r;
    res_o.ovf = ovf_r;
  end

  // Command sequencer: a scan's table access is a read, a wait for the data,
  // then a decision and an optional write back; the clearing pass and the alloc run only write.
  always_comb begin
    logic [CNT_W-1:0]  run_inc;
    logic [CNT_W:0]    hsum;
    logic [BLK_W-1:0]  hval;
    logic [32:0]       hi;
    logic [31:0]       diff;
    logic [CNT_W-1:0]  pos;
    logic [32:0]       need_sum;
    logic [NEED_W-1:0] need_v;
    logic [BLK_W-1:0]  last_v;

    state_nxt    = state_r;
    res_nxt      = res_r;
    need_nxt     = need_r;
    val_nxt      = val_r;
    cur_nxt      = cur_r;
    walk_nxt     = walk_r;
    ptr_nxt      = ptr_r;
    blk_nxt      = blk_r;
    run_nxt      = run_r;
    last_nxt     = last_r;
    drop_nxt     = drop_r;
    pass_nxt     = pass_r;
    scnt_nxt     = scnt_r;
    ovf_nxt      = ovf_r;
    hint_nxt     = hint_r;
    hu_nxt       = hu_r;
    active_nxt   = active_r;
    clr_emit_nxt = clr_emit_r;

    tab_we    = 1'b0;
    tab_waddr = ptr_r;
    tab_wdata = K_FREE;
    tab_raddr = cur_r[BLK_W-1:0];
    stk_we    = 1'b0;
    stk_waddr = scnt_r[STK_W-1:0];
    stk_wdata = blk_r;
    stk_raddr = scnt_r[STK_W-1:0];

    run_inc  = run_r + CNT_W'(1);
    hsum     = {1'b0, cur_r} + (CNT_W + 1)'(1);
    hval     = hsum[CNT_W:2];
    hi       = {1'b0, cfg.base} + 33'({nb, {OFS_W{1'b0}}});
    diff     = val_r - cfg.base;
    pos      = {1'b0, blk_r} + run_r;
    need_sum = {1'b0, in_data.value} + 33'(BLOCK_BYTES - 1);
    need_v   = need_sum[32:OFS_W];
    last_v   = last_r;

    case (state_r)
      // Clearing pass over the whole table, one entry a cycle.
      S_CLEAR: begin
        tab_we    = 1'b1;
        tab_waddr = cur_r[BLK_W-1:0];
        tab_wdata = K_FREE;
        if (cur_r[BLK_W-1:0] == LAST_BLK) begin
          if (clr_emit_r) begin
            res_nxt   = mk_res(ST_DONE, '0, '0, 1'b0);
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          cur_nxt = cur_r + CNT_W'(1);
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          case (in_data.command)
            CMD_INIT: begin
              scnt_nxt     = '0;
              ovf_nxt      = 1'b0;
              hint_nxt     = '0;
              hu_nxt       = '0;
              walk_nxt     = '0;
              active_nxt   = 1'b0;
              cur_nxt      = '0;
              clr_emit_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
            CMD_ALLOC: begin
              need_nxt  = (need_v == '0) ? NEED_W'(1) : need_v;
              cur_nxt   = {1'b0, hint_r, 2'b00};
              run_nxt   = '0;
              state_nxt = S_A_RD;
            end
            CMD_MARK: begin
              val_nxt   = in_data.value;
              state_nxt = S_M_CHK;
            end
            CMD_POP: begin
              if (scnt_r == '0) begin
                res_nxt   = mk_res(ST_EMPTY, '0, '0, 1'b0);
                state_nxt = S_OUT;
              end else begin
                scnt_nxt  = scnt_r - SCNT_W'(1);
                state_nxt = S_P_RD;
              end
            end
            CMD_RESCAN: begin
              pass_nxt  = 1'b0;
              state_nxt = S_R_START;
            end
            CMD_SWEEP: begin
              cur_nxt   = '0;
              drop_nxt  = 1'b0;
              last_nxt  = '0;
              state_nxt = S_W_RD;
            end
            default: begin
              res_nxt   = mk_res(ST_IGNORED, '0, '0, 1'b0);
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      // First-fit scan from the free hint.
      S_A_RD: begin
        if (cur_r >= nb) begin
          res_nxt   = mk_res(ST_OOM, '0, '0, 1'b0);
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_A_EV;
        end
      end

      S_A_EV: begin
        if (tab_rdata == K_FREE) begin
          if (NEED_W'(run_inc) >= need_r) begin
            blk_nxt = cur_r[BLK_W-1:0] - run_r[BLK_W-1:0];
            ptr_nxt = cur_r[BLK_W-1:0] - run_r[BLK_W-1:0];
            run_nxt = run_inc;
            if (run_inc == CNT_W'(1)) begin
              hint_nxt = (hval >= BLK_W'(MAX_BLOCKS / 4)) ? '0 : hval[HINT_W-1:0];
            end
            if (cur_r[BLK_W-1:0] > hu_r) begin
              hu_nxt = cur_r[BLK_W-1:0];
            end
            state_nxt = S_A_WR;
          end else begin
            run_nxt   = run_inc;
            cur_nxt   = cur_r + CNT_W'(1);
            state_nxt = S_A_RD;
          end
        end else begin
          run_nxt   = '0;
          cur_nxt   = cur_r + CNT_W'(1);
          state_nxt = S_A_RD;
        end
      end

      // Write the head, then the tails up to the last block of the run.
      S_A_WR: begin
        tab_we    = 1'b1;
        tab_waddr = ptr_r;
        tab_wdata = (ptr_r == blk_r) ? K_HEAD : K_TAIL;
        if (ptr_r == cur_r[BLK_W-1:0]) begin
          res_nxt   = mk_res(ST_DONE, blk_r, run_r, 1'b1);
          state_nxt = S_OUT;
        end else begin
          ptr_nxt = ptr_r + BLK_W'(1);
        end
      end

      // Alignment and range check of a candidate pointer.
      S_M_CHK: begin
        if ((val_r[OFS_W-1:0] != '0) || (val_r < cfg.base) || ({1'b0, val_r} >= hi)) begin
          res_nxt   = mk_res(ST_IGNORED, '0, '0, 1'b0);
          state_nxt = S_OUT;
        end else begin
          blk_nxt   = diff[OFS_W+BLK_W-1:OFS_W];
          state_nxt = S_M_RD;
        end
      end

      S_M_RD: begin
        tab_raddr = blk_r;
        state_nxt = S_M_EV;
      end

      S_M_EV: begin
        if (tab_rdata != K_HEAD) begin
          res_nxt = mk_res(ST_IGNORED, '0, '0, 1'b0);
        end else begin
          tab_we    = 1'b1;
          tab_waddr = blk_r;
          tab_wdata = K_MARK;
          if (scnt_r < SCNT_W'(STACK_DEPTH)) begin
            stk_we   = 1'b1;
            scnt_nxt = scnt_r + SCNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          res_nxt = mk_res(ST_DONE, blk_r, '0, 1'b1);
        end
        state_nxt = S_OUT;
      end

      // Pop the top of the trace stack.
      S_P_RD: begin
        state_nxt = S_P_EV;
      end

      S_P_EV: begin
        blk_nxt   = stk_rdata;
        run_nxt   = CNT_W'(1);
        state_nxt = S_L_RD;
      end

      // Object length: count tails that follow the head, up to the pool end.
      S_L_RD: begin
        if (pos >= nb) begin
          res_nxt   = mk_res(ST_DONE, blk_r, run_r, 1'b1);
          state_nxt = S_OUT;
        end else begin
          tab_raddr = pos[BLK_W-1:0];
          state_nxt = S_L_EV;
        end
      end

      S_L_EV: begin
        if (tab_rdata == K_TAIL) begin
          run_nxt   = run_inc;
          state_nxt = S_L_RD;
        end else begin
          res_nxt   = mk_res(ST_DONE, blk_r, run_r, 1'b1);
          state_nxt = S_OUT;
        end
      end

      // Overflow rescan: walk the table for marked heads.
      S_R_START: begin
        if (!active_r) begin
          if (!ovf_r) begin
            res_nxt   = mk_res(ST_EMPTY, '0, '0, 1'b0);
            state_nxt = S_OUT;
          end else begin
            ovf_nxt    = 1'b0;
            active_nxt = 1'b1;
            walk_nxt   = '0;
            state_nxt  = S_R_RD;
          end
        end else begin
          state_nxt = S_R_RD;
        end
      end

      S_R_RD: begin
        if (walk_r >= nb) begin
          active_nxt = 1'b0;
          if (!pass_r) begin
            pass_nxt  = 1'b1;
            state_nxt = S_R_START;
          end else begin
            res_nxt   = mk_res(ST_EMPTY, '0, '0, 1'b0);
            state_nxt = S_OUT;
          end
        end else begin
          tab_raddr = walk_r[BLK_W-1:0];
          blk_nxt   = walk_r[BLK_W-1:0];
          walk_nxt  = walk_r + CNT_W'(1);
          state_nxt = S_R_EV;
        end
      end

      S_R_EV: begin
        if (tab_rdata == K_MARK) begin
          run_nxt   = CNT_W'(1);
          state_nxt = S_L_RD;
        end else begin
          state_nxt = S_R_RD;
        end
      end

      // Sweep from block zero to the highest used block.
      S_W_RD: begin
        state_nxt = S_W_EV;
      end

      S_W_EV: begin
        tab_waddr = cur_r[BLK_W-1:0];
        case (tab_rdata)
          K_HEAD: begin
            drop_nxt = 1'b1;
            tab_we   = 1'b1;
          end
          K_TAIL: begin
            if (drop_r) begin
              tab_we = 1'b1;
            end else begin
              last_v = cur_r[BLK_W-1:0];
            end
          end
          K_MARK: begin
            tab_we    = 1'b1;
            tab_wdata = K_HEAD;
            drop_nxt  = 1'b0;
            last_v    = cur_r[BLK_W-1:0];
          end
          default: begin
          end
        endcase
        last_nxt = last_v;
        if ((cur_r[BLK_W-1:0] == hu_r) || (cur_r[BLK_W-1:0] == LAST_BLK)) begin
          hu_nxt    = last_v;
          hint_nxt  = '0;
          res_nxt   = mk_res(ST_DONE, '0, '0, 1'b0);
          state_nxt = S_OUT;
        end else begin
          cur_nxt   = cur_r + CNT_W'(1);
          state_nxt = S_W_RD;
        end
      end

      S_OUT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      cur_r      <= '0;
      walk_r     <= '0;
      scnt_r     <= '0;
      ovf_r      <= 1'b0;
      hint_r     <= '0;
      hu_r       <= '0;
      active_r   <= 1'b0;
      clr_emit_r <= 1'b0;
      pass_r     <= 1'b0;
      drop_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_r      <= cur_nxt;
      walk_r     <= walk_nxt;
      scnt_r     <= scnt_nxt;
      ovf_r      <= ovf_nxt;
      hint_r     <= hint_nxt;
      hu_r       <= hu_nxt;
      active_r   <= active_nxt;
      clr_emit_r <= clr_emit_nxt;
      pass_r     <= pass_nxt;
      drop_r     <= drop_nxt;
    end
    res_r  <= res_nxt;
    need_r <= need_nxt;
    val_r  <= val_nxt;
    ptr_r  <= ptr_nxt;
    blk_r  <= blk_nxt;
    run_r  <= run_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== rtl/block_table_heap_mark_sweep_core.sv =====
`timescale 1ns / 1ps
// Block-table heap manager for a mark-sweep collector: a 2-bit kind per
// 16-byte block in a synchronous table memory, plus a 64-entry trace stack
// memory. Each command yields one result. A table visit in a scan is a
// read, then a decision and an optional write back; alloc scans blocks
// from its hint and then writes its run, sweep visits blocks up to the
// highest used block, pop and rescan visit each tail counted (and each
// block walked), mark_word visits one entry, and init clears the whole
// table in its clearing pass. After reset the same clearing pass runs
// before the first transfer is taken; configuration writes are taken at
// any time. A finished result is held in an output register, so the next
// command is accepted while it waits to be taken.
module block_table_heap_mark_sweep_core
  import bth_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t             cfg_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             tab_we;
  logic [BLK_W-1:0] tab_waddr;
  logic [1:0]       tab_wdata;
  logic [BLK_W-1:0] tab_raddr;
  logic [1:0]       tab_rdata;
  logic             stk_we;
  logic [STK_W-1:0] stk_waddr;
  logic [BLK_W-1:0] stk_wdata;
  logic [STK_W-1:0] stk_raddr;
  logic [BLK_W-1:0] stk_rdata;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base   <= '0;
      cfg_r.blocks <= CNT_W'(MAX_BLOCKS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POOL_BASE:   cfg_r.base   <= cfg_data;
        CFG_POOL_BLOCKS: cfg_r.blocks <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bth_ram #(.WIDTH(2), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  bth_ram #(.WIDTH(BLK_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  bth_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_o     (res),
    .tab_we    (tab_we),
    .tab_waddr (tab_waddr),
    .tab_wdata (tab_wdata),
    .tab_raddr (tab_raddr),
    .tab_rdata (tab_rdata),
    .stk_we    (stk_we),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_raddr (stk_raddr),
    .stk_rdata (stk_rdata)
  );

  // Output register; the block address is formed as the result is loaded.
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_data_r.status      <= res.status;
      out_data_r.block_index <= res.blk;
      out_data_r.block_count <= res.cnt;
      out_data_r.address     <= res.has_addr ?
                                (cfg_r.base + {{(32-BLK_W-OFS_W){1'b0}}, res.blk,
                                               {OFS_W{1'b0}}}) : 32'd0;
      out_data_r.overflowed  <= res.ovf;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
